[rtl/rls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rls_pkg;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned STATUS_W = 2;

   // Both channels carry 66 payload bits, padded to whole bytes.
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_TOP  = 2'd2,
      OP_SIZE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_HALTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_CMP,
      ST_POP_DROP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic count_en;
      logic value_en;
   } store_wen_type;

endpackage

`default_nettype wire

[rtl/run_length_stack_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata: operation, count, item_value
// rsp      out        rsp_tvalid/tready    tdata: status, top_value, total
// csr      in         csr_wr_en            csr_wr_data: capacity
//
// One item is worked on at a time by a sequencer around a single 33-bit add/subtract unit.
// Push, size, a halted transaction, a pop of nothing and any failure answer from the execute state;
// a top answers from the finish state; any other pop alternates compare and drop states, dropping whole
// runs and perhaps shortening the last; the run store's registered read port sets the pop walk.
// Reset is synchronous; it empties the stack, clears the halt and sets the capacity to zero.
// A stalled response holds in the output register while the next request is accepted.

module run_length_stack_core #(
   parameter int RUN_DEPTH = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // operation [1:0], count [33:2], item_value [65:34]
   input  wire logic [rls_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status [1:0], top_value [33:2], total [65:34]
   output logic      [rls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [rls_pkg::WORD_W-1:0]        csr_wr_data
);

   localparam int PTR_W = $clog2(RUN_DEPTH + 1);
   localparam int IDX_W = $clog2(RUN_DEPTH);

   rls_pkg::state_type           state_ff, state_in;
   rls_pkg::op_type              op_ff, op_in;
   logic [rls_pkg::WORD_W-1:0]   count_ff, count_in;
   logic [rls_pkg::WORD_W-1:0]   value_ff, value_in;
   logic [rls_pkg::WORD_W-1:0]   capacity_ff, capacity_in;
   logic [rls_pkg::WORD_W-1:0]   total_ff, total_in;
   logic [rls_pkg::WORD_W-1:0]   left_ff, left_in;
   logic [PTR_W-1:0]             ptr_ff, ptr_in;
   logic                         halted_ff, halted_in;
   logic                         top_sel_ff, top_sel_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   rls_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic signed [rls_pkg::WORD_W-1:0] rsp_top_ff, rsp_top_in;
   logic [rls_pkg::WORD_W-1:0]   rsp_total_ff, rsp_total_in;

   logic [rls_pkg::WORD_W-1:0]   alu_a, alu_b;
   logic                         alu_sub;
   logic [rls_pkg::WORD_W:0]     alu_res;

   rls_pkg::store_wen_type       st_wen;
   logic [IDX_W-1:0]             st_wr_addr;
   logic [rls_pkg::WORD_W-1:0]   st_wr_count;
   logic                         st_rd_en;
   logic [IDX_W-1:0]             st_rd_addr;
   logic [rls_pkg::WORD_W-1:0]   st_rd_count;
   logic [rls_pkg::WORD_W-1:0]   st_rd_value;

   logic [PTR_W-1:0]             ptr_m1;
   logic [PTR_W-1:0]             ptr_m2;
   logic                         store_full;
   logic                         out_free;
   logic                         req_fire;

   assign ptr_m1     = ptr_ff - PTR_W'(1);
   assign ptr_m2     = ptr_ff - PTR_W'(2);
   assign store_full = (ptr_ff == PTR_W'(RUN_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == rls_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Operand selection for the shared add/subtract unit.
   always_comb begin
      alu_a   = total_ff;
      alu_b   = count_ff;
      alu_sub = 1'b0;
      unique case (state_ff)
         rls_pkg::ST_EXEC: begin
            alu_a   = total_ff;
            alu_b   = count_ff;
            alu_sub = (op_ff != rls_pkg::OP_PUSH);
         end
         rls_pkg::ST_POP_CMP: begin
            alu_a   = st_rd_count;
            alu_b   = left_ff;
            alu_sub = 1'b1;
         end
         rls_pkg::ST_POP_DROP: begin
            alu_a   = left_ff;
            alu_b   = st_rd_count;
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // Bit 32 is the carry of an add and the borrow of a subtract.
   assign alu_res = {1'b0, alu_a}
                  + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                  + {{rls_pkg::WORD_W{1'b0}}, alu_sub};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      value_in      = value_ff;
      capacity_in   = csr_wr_en ? csr_wr_data : capacity_ff;
      total_in      = total_ff;
      left_in       = left_ff;
      ptr_in        = ptr_ff;
      halted_in     = halted_ff;
      top_sel_in    = top_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_total_in  = rsp_total_ff;
      st_wen        = '0;
      st_wr_addr    = ptr_ff[IDX_W-1:0];
      st_wr_count   = count_ff;
      st_rd_en      = 1'b0;
      st_rd_addr    = ptr_m1[IDX_W-1:0];

      unique case (state_ff)
         rls_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = rls_pkg::op_type'(req_tdata[1:0]);
               count_in = req_tdata[33:2];
               value_in = req_tdata[65:34];
               state_in = rls_pkg::ST_EXEC;
            end
         end

         rls_pkg::ST_EXEC: begin
            if (halted_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rls_pkg::STATUS_HALTED;
                  rsp_top_in    = '0;
                  rsp_total_in  = total_ff;
                  state_in      = rls_pkg::ST_IDLE;
               end
            end else begin
               unique case (op_ff)
                  rls_pkg::OP_PUSH: begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_top_in   = '0;
                        state_in     = rls_pkg::ST_IDLE;
                        if ((alu_res > {1'b0, capacity_ff}) ||
                            ((count_ff != '0) && store_full)) begin
                           rsp_status_in = rls_pkg::STATUS_FULL;
                           rsp_total_in  = total_ff;
                           halted_in     = 1'b1;
                        end else begin
                           rsp_status_in = rls_pkg::STATUS_OK;
                           rsp_total_in  = total_ff;
                           // A push of nothing stores no run.
                           if (count_ff != '0) begin
                              st_wen.count_en = 1'b1;
                              st_wen.value_en = 1'b1;
                              ptr_in          = ptr_ff + PTR_W'(1);
                              total_in        = alu_res[rls_pkg::WORD_W-1:0];
                              rsp_total_in    = alu_res[rls_pkg::WORD_W-1:0];
                           end
                        end
                     end
                  end

                  rls_pkg::OP_POP: begin
                     if (alu_res[rls_pkg::WORD_W]) begin
                        if (out_free) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = rls_pkg::STATUS_EMPTY;
                           rsp_top_in    = '0;
                           rsp_total_in  = total_ff;
                           halted_in     = 1'b1;
                           state_in      = rls_pkg::ST_IDLE;
                        end
                     end else if (count_ff == '0) begin
                        if (out_free) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = rls_pkg::STATUS_OK;
                           rsp_top_in    = '0;
                           rsp_total_in  = total_ff;
                           state_in      = rls_pkg::ST_IDLE;
                        end
                     end else begin
                        // The total is settled now; the walk below only trims the runs.
                        total_in = alu_res[rls_pkg::WORD_W-1:0];
                        left_in  = count_ff;
                        st_rd_en = 1'b1;
                        state_in = rls_pkg::ST_POP_CMP;
                     end
                  end

                  rls_pkg::OP_TOP: begin
                     if ((total_ff == '0) || (ptr_ff == '0)) begin
                        if (out_free) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = rls_pkg::STATUS_EMPTY;
                           rsp_top_in    = '0;
                           rsp_total_in  = total_ff;
                           halted_in     = 1'b1;
                           state_in      = rls_pkg::ST_IDLE;
                        end
                     end else begin
                        st_rd_en   = 1'b1;
                        top_sel_in = 1'b1;
                        state_in   = rls_pkg::ST_FINISH;
                     end
                  end

                  rls_pkg::OP_SIZE: begin
                     if (out_free) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rls_pkg::STATUS_OK;
                        rsp_top_in    = '0;
                        rsp_total_in  = total_ff;
                        state_in      = rls_pkg::ST_IDLE;
                     end
                  end

                  default: begin
                     state_in = rls_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         rls_pkg::ST_POP_CMP: begin
            // The top run outlasts what is left to remove: shorten it and stop.
            if (!alu_res[rls_pkg::WORD_W] && (alu_res[rls_pkg::WORD_W-1:0] != '0)) begin
               st_wen.count_en = 1'b1;
               st_wr_addr      = ptr_m1[IDX_W-1:0];
               st_wr_count     = alu_res[rls_pkg::WORD_W-1:0];
               top_sel_in      = 1'b0;
               state_in        = rls_pkg::ST_FINISH;
            end else begin
               state_in = rls_pkg::ST_POP_DROP;
            end
         end

         rls_pkg::ST_POP_DROP: begin
            left_in = alu_res[rls_pkg::WORD_W-1:0];
            ptr_in  = ptr_m1;
            if ((alu_res[rls_pkg::WORD_W-1:0] == '0) || (ptr_m1 == '0)) begin
               top_sel_in = 1'b0;
               state_in   = rls_pkg::ST_FINISH;
            end else begin
               st_rd_en   = 1'b1;
               st_rd_addr = ptr_m2[IDX_W-1:0];
               state_in   = rls_pkg::ST_POP_CMP;
            end
         end

         rls_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rls_pkg::STATUS_OK;
               rsp_top_in    = top_sel_ff ? st_rd_value : '0;
               rsp_total_in  = total_ff;
               state_in      = rls_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rls_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rls_pkg::ST_IDLE;
         capacity_ff  <= '0;
         total_ff     <= '0;
         ptr_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         total_ff     <= total_in;
         ptr_ff       <= ptr_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      count_ff      <= count_in;
      value_ff      <= value_in;
      left_ff       <= left_in;
      top_sel_ff    <= top_sel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_total_ff  <= rsp_total_in;
   end

   rls_run_store #(
      .DEPTH (RUN_DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (st_wen),
      .wr_addr  (st_wr_addr),
      .wr_count (st_wr_count),
      .wr_value (value_ff),
      .rd_en    (st_rd_en),
      .rd_addr  (st_rd_addr),
      .rd_count (st_rd_count),
      .rd_value (st_rd_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_total_ff, rsp_top_ff, rsp_status_ff};

endmodule

`default_nettype wire

[rtl/rls_run_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module rls_run_store #(
   parameter int DEPTH = 256,
   parameter int IDX_W = 8
) (
   input  wire logic                         clock,
   input  wire rls_pkg::store_wen_type       wr_en,
   input  wire logic [IDX_W-1:0]             wr_addr,
   input  wire logic [rls_pkg::WORD_W-1:0]   wr_count,
   input  wire logic [rls_pkg::WORD_W-1:0]   wr_value,
   input  wire logic                         rd_en,
   input  wire logic [IDX_W-1:0]             rd_addr,
   output logic      [rls_pkg::WORD_W-1:0]   rd_count,
   output logic      [rls_pkg::WORD_W-1:0]   rd_value
);

   logic [rls_pkg::WORD_W-1:0] count_mem [DEPTH];
   logic [rls_pkg::WORD_W-1:0] value_mem [DEPTH];
   logic [rls_pkg::WORD_W-1:0] rd_count_ff;
   logic [rls_pkg::WORD_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en.count_en) begin
         count_mem[wr_addr] <= wr_count;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en.value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
   end

   // The read data holds until the next read, so the sequencer may use it over several cycles.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_count_ff <= count_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
      end
   end

   assign rd_count = rd_count_ff;
   assign rd_value = rd_value_ff;

endmodule

`default_nettype wire

[rtl/rls_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rls_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [rls_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic seen_fail_ff, seen_fail_in;
   logic rsp_fire;
   logic [1:0] rsp_status;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_status = rsp_tdata[1:0];

   // Remembers that a full or empty response has already been handed over.
   assign seen_fail_in = seen_fail_ff ||
                         (rsp_fire && ((rsp_status == rls_pkg::STATUS_FULL) ||
                                       (rsp_status == rls_pkg::STATUS_EMPTY)));

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fail_ff <= 1'b0;
      end else begin
         seen_fail_ff <= seen_fail_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or vanished");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while the previous one is still in work");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && seen_fail_ff |-> rsp_status == rls_pkg::STATUS_HALTED)
      else $error("response after a failure is not reported as halted");

   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != rls_pkg::STATUS_OK) |-> rsp_tdata[33:2] == '0)
      else $error("failed transaction carries a top value");

   a_top_needs_elements: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:2] != '0) |-> rsp_tdata[65:34] != '0)
      else $error("top value reported while the stack is empty");

endmodule

bind run_length_stack_core rls_checker u_rls_checker (.*);

`default_nettype wire

[test/run_length_stack_checker.sv]
`timescale 1ns / 1ps

module run_length_stack_checker #(
   parameter int RUN_DEPTH = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // operation [1:0], count [33:2], item_value [65:34]
   input  wire logic [rls_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status [1:0], top_value [33:2], total [65:34]
   input  wire logic [rls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [rls_pkg::WORD_W-1:0]        csr_wr_data,
   output int unsigned                            failures,
   output int unsigned                            outstanding
);

   typedef struct packed {
      rls_pkg::status_type status;
      logic signed [31:0]  top_value;
      logic [31:0]         total;
   } stack_result_type;

   // Shadow of the stack contents and the capacity register.
   logic [31:0]        run_len [RUN_DEPTH];
   logic signed [31:0] run_val [RUN_DEPTH];
   int unsigned        run_cnt = 0;
   logic [31:0]        held = '0;
   logic [31:0]        capacity = '0;
   bit                 halted = 1'b0;
   int unsigned        mismatch_total = 0;
   stack_result_type   result_q[$];

   function automatic stack_result_type apply_request(rls_pkg::op_type op, logic [31:0] n,
                                                      logic signed [31:0] v);
      stack_result_type r;
      logic [32:0]      sum;
      logic [31:0]      left;
      r.status    = rls_pkg::STATUS_OK;
      r.top_value = '0;
      if (halted) begin
         r.status = rls_pkg::STATUS_HALTED;
      end else begin
         case (op)
            rls_pkg::OP_PUSH: begin
               sum = {1'b0, held} + {1'b0, n};
               if (sum > {1'b0, capacity} || (n != 0 && run_cnt >= RUN_DEPTH)) begin
                  halted   = 1'b1;
                  r.status = rls_pkg::STATUS_FULL;
               end else if (n != 0) begin
                  run_len[run_cnt] = n;
                  run_val[run_cnt] = v;
                  run_cnt++;
                  held = sum[31:0];
               end
            end
            rls_pkg::OP_POP: begin
               if (n > held) begin
                  halted   = 1'b1;
                  r.status = rls_pkg::STATUS_EMPTY;
               end else begin
                  held = held - n;
                  left = n;
                  // Shorten the top run or drop whole runs until the count is used up.
                  while (left != 0 && run_cnt != 0) begin
                     if (run_len[run_cnt-1] > left) begin
                        run_len[run_cnt-1] = run_len[run_cnt-1] - left;
                        left = '0;
                     end else begin
                        left = left - run_len[run_cnt-1];
                        run_cnt--;
                     end
                  end
               end
            end
            rls_pkg::OP_TOP: begin
               if (held == 0 || run_cnt == 0) begin
                  halted   = 1'b1;
                  r.status = rls_pkg::STATUS_EMPTY;
               end else begin
                  r.top_value = run_val[run_cnt-1];
               end
            end
            default: ;
         endcase
      end
      r.total = held;
      return r;
   endfunction

   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type want;
      if (reset) begin
         run_cnt  = 0;
         held     = '0;
         capacity = '0;
         halted   = 1'b0;
         result_q.delete();
      end else begin
         if (csr_wr_en) begin
            capacity = csr_wr_data;
         end
         // The response is compared before the request of the same edge is predicted.
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rls_pkg::status_type'(rsp_tdata[1:0]);
            got.top_value = rsp_tdata[33:2];
            got.total     = rsp_tdata[65:34];
            if (result_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("[%0t] unexpected response: status %0d top %0d total %0d",
                           $time, got.status, got.top_value, got.total);
               end
            end else begin
               want = result_q.pop_front();
               if (got.status !== want.status || got.top_value !== want.top_value ||
                   got.total !== want.total) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("[%0t] response mismatch: expected status %0d top %0d total %0d",
                              $time, want.status, want.top_value, want.total);
                     $display("[%0t]                    actual   status %0d top %0d total %0d",
                              $time, got.status, got.top_value, got.total);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            result_q.push_back(apply_request(rls_pkg::op_type'(req_tdata[1:0]),
                                             req_tdata[33:2], req_tdata[65:34]));
         end
      end
      outstanding <= result_q.size();
      failures    <= mismatch_total;
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int STACK_DEPTH    = 256;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 210;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // operation [1:0], count [33:2], item_value [65:34]
   logic [rls_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // status [1:0], top_value [33:2], total [65:34]
   logic [rls_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wr_en = 1'b0;
   logic [rls_pkg::WORD_W-1:0]     csr_wr_data = '0;

   int unsigned           mismatches;
   int unsigned           in_flight;
   logic                  long_hold_req = 1'b0;

   // Sender-side bookkeeping, used only to keep the stimulus legal until the final failure.
   logic [31:0]           held_total = '0;
   logic [31:0]           cap_now = '0;
   int unsigned           runs_bound = 0;
   int unsigned           burst_left = 0;
   bit                    gaps_on = 1'b1;

   always #5 clock = ~clock;

   run_length_stack_core #(
      .RUN_DEPTH(STACK_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   run_length_stack_checker #(
      .RUN_DEPTH(STACK_DEPTH)
   ) stack_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .failures   (mismatches),
      .outstanding(in_flight)
   );

   // Response side: short stalls, long clean stretches, and one long hold on request.
   int unsigned ready_left = 0;
   int unsigned stall_left = 0;
   bit          long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         stall_left     <= LONG_HOLD;
         ready_left     <= 0;
         rsp_tready     <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (ready_left != 0) begin
         ready_left <= ready_left - 1;
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            ready_left <= $urandom_range(40, 120);
         end else begin
            ready_left <= $urandom_range(0, 8);
            stall_left <= $urandom_range(1, 5);
         end
      end
   end

   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] below(logic [31:0] limit);
      return (limit == '1) ? $urandom : $urandom_range(0, limit);
   endfunction

   task automatic send_request(rls_pkg::op_type op, logic [31:0] n, logic [31:0] v);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 10);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rls_pkg::REQ_DATA_W-66){1'b0}}, v, n, op};
      do @(posedge clock); while (!req_tready);
      if (op == rls_pkg::OP_PUSH && n != 0) begin
         held_total = held_total + n;
         runs_bound++;
      end else if (op == rls_pkg::OP_POP) begin
         held_total = held_total - n;
         if (held_total == 0) begin
            runs_bound = 0;
         end
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(logic [31:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_now = v;
   endtask

   task automatic random_request(int unsigned push_bias);
      int unsigned     pick;
      rls_pkg::op_type op;
      logic [31:0]     n;
      logic [31:0]     room;
      pick = $urandom_range(0, 99);
      room = cap_now - held_total;
      if (pick < push_bias) begin
         op = rls_pkg::OP_PUSH;
      end else if (pick < push_bias + 30) begin
         op = rls_pkg::OP_POP;
      end else if (pick < push_bias + 45) begin
         op = rls_pkg::OP_TOP;
      end else begin
         op = rls_pkg::OP_SIZE;
      end
      if (op == rls_pkg::OP_PUSH && runs_bound >= STACK_DEPTH) begin
         op = rls_pkg::OP_POP;
      end
      if (op == rls_pkg::OP_TOP && held_total == 0) begin
         op = rls_pkg::OP_SIZE;
      end
      n = $urandom;
      if (op == rls_pkg::OP_PUSH) begin
         case ($urandom_range(0, 9))
            0:       n = '0;
            1:       ;
            2, 3:    n = $urandom_range(0, 1000);
            default: n = $urandom_range(1, 8);
         endcase
         if (n > room) begin
            n = below(room);
         end
      end else if (op == rls_pkg::OP_POP) begin
         case ($urandom_range(0, 9))
            0:       n = '0;
            1:       n = held_total;
            2, 3:    n = below(held_total);
            default: n = $urandom_range(1, 16);
         endcase
         if (n > held_total) begin
            n = held_total;
         end
      end
      send_request(op, n, $urandom);
   endtask

   // With hold set, the receiver stalls for a long stretch while this phase keeps sending.
   task automatic run_phase(logic [31:0] cap, int unsigned push_bias, bit gaps, bit hold);
      if (held_total != 0) begin
         send_request(rls_pkg::OP_POP, held_total, $urandom);
      end
      wait_idle();
      write_capacity(cap);
      long_hold_req <= hold;
      gaps_on = gaps;
      repeat (PHASE_ITEMS) random_request(push_bias);
   endtask

   // A failure halts the block until reset, so only one can be provoked per run;
   // its kind is picked at random.
   task automatic provoke_halt();
      int unsigned kind;
      logic [31:0] n;
      kind = $urandom_range(0, 3);
      if (held_total != 0) begin
         send_request(rls_pkg::OP_POP, held_total, $urandom);
      end
      wait_idle();
      write_capacity((kind == 0 && $urandom_range(0, 1) == 1) ? $urandom : 32'hFFFF_FFFF);
      gaps_on = 1'b1;
      case (kind)
         0: begin
            // Total would pass the capacity.
            if (cap_now != 0) begin
               send_request(rls_pkg::OP_PUSH, cap_now, $urandom);
            end
            n = $urandom;
            if (n == 0) begin
               n = 1;
            end
            send_request(rls_pkg::OP_PUSH, n, $urandom);
         end
         1: begin
            // Every run slot taken.
            repeat (STACK_DEPTH) begin
               send_request(rls_pkg::OP_PUSH, $urandom_range(1, 1000), $urandom);
            end
            send_request(rls_pkg::OP_PUSH, $urandom_range(1, 1000), $urandom);
         end
         2: begin
            if ($urandom_range(0, 1) == 1) begin
               send_request(rls_pkg::OP_PUSH, $urandom_range(1, 50), $urandom);
            end
            send_request(rls_pkg::OP_POP, held_total + $urandom_range(1, 50), $urandom);
         end
         default: send_request(rls_pkg::OP_TOP, $urandom, $urandom);
      endcase
      repeat ($urandom_range(4, 8)) begin
         send_request(rls_pkg::op_type'($urandom_range(0, 3)), $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Capacity is zero after reset: only empty pushes and pops fit.
      send_request(rls_pkg::OP_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rls_pkg::OP_PUSH, 32'd0, 32'h7FFF_FFFF);
      send_request(rls_pkg::OP_POP, 32'd0, 32'h8000_0000);
      send_request(rls_pkg::OP_SIZE, 32'd0, 32'd0);
      wait_idle();
      write_capacity(32'hFFFF_FFFF);

      send_request(rls_pkg::OP_PUSH, 32'd1, 32'h7FFF_FFFF);
      send_request(rls_pkg::OP_PUSH, 32'hFFFF_FFFE, 32'h8000_0000);
      send_request(rls_pkg::OP_TOP, 32'd0, 32'd0);
      send_request(rls_pkg::OP_SIZE, 32'd0, 32'd0);
      send_request(rls_pkg::OP_PUSH, 32'd0, 32'h1234_5678);
      send_request(rls_pkg::OP_POP, 32'hFFFF_FFFE, 32'd0);
      send_request(rls_pkg::OP_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rls_pkg::OP_PUSH, 32'd0, 32'hFFFF_FFFF);
      send_request(rls_pkg::OP_TOP, 32'd0, 32'd0);
      send_request(rls_pkg::OP_POP, 32'd1, 32'd0);
      send_request(rls_pkg::OP_SIZE, 32'd0, 32'd0);
      send_request(rls_pkg::OP_PUSH, 32'd3, 32'd5);
      send_request(rls_pkg::OP_PUSH, 32'd2, 32'hFFFF_FFFF);
      send_request(rls_pkg::OP_POP, 32'd3, 32'd0);
      send_request(rls_pkg::OP_TOP, 32'd0, 32'd0);
      send_request(rls_pkg::OP_POP, 32'd2, 32'd0);
      send_request(rls_pkg::OP_SIZE, 32'd0, 32'd0);

      run_phase(32'hFFFF_FFFF, 45, 1'b1, 1'b0);
      run_phase($urandom_range(16, 4096), 60, 1'b1, 1'b1);
      run_phase(32'd1, 40, 1'b0, 1'b0);
      run_phase($urandom, 50, 1'b1, 1'b0);
      run_phase(32'hFFFF_FFFF, 70, 1'b0, 1'b0);
      provoke_halt();
      wait_idle();

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
